[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/spmv_pkg.sv]
package spmv_pkg;

   // Storage and value sizes.
   localparam int VALUE_WIDTH = 32;
   localparam int X_DEPTH     = 1024;
   localparam int X_ADDR_W    = $clog2(X_DEPTH);
   localparam int VLEN_W      = X_ADDR_W + 1;

   // Shared multiplier: signed operands one bit wider than a value so that the
   // low word of the accumulator can enter as an unsigned number.
   localparam int MUL_W  = VALUE_WIDTH + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 2 * VALUE_WIDTH;
   localparam int BETA_SHIFT = 16;

   // Request tdata layout, lowest field first.
   localparam int XI_LSB     = 0;
   localparam int XV_LSB     = XI_LSB + X_ADDR_W;
   localparam int MV_LSB     = XV_LSB + VALUE_WIDTH;
   localparam int COL_LSB    = MV_LSB + VALUE_WIDTH;
   localparam int OY_LSB     = COL_LSB + X_ADDR_W;
   localparam int ME_BIT     = OY_LSB + VALUE_WIDTH;
   localparam int REQ_DATA_W = ((ME_BIT + 1 + 7) / 8) * 8;

   localparam int RSP_DATA_W = VALUE_WIDTH;
   localparam int RSP_USER_W = 2;

   // Request kinds carried on tuser.
   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_NONZERO = 2'd1,
      ACT_EMPTY   = 2'd2
   } action_type;

   // Control register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VLEN  = 2'd2;

   localparam logic [VALUE_WIDTH-1:0] ALPHA_RESET = VALUE_WIDTH'(65536);
   localparam logic [VLEN_W-1:0]      VLEN_RESET  = VLEN_W'(X_DEPTH);
   localparam logic [VLEN_W-1:0]      X_DEPTH_LEN = VLEN_W'(X_DEPTH);

endpackage

[hdl/spmv_mul.sv]
// Shared signed multiplier with a registered product.
module spmv_mul (
   input  logic                                 clock,
   input  logic signed [spmv_pkg::MUL_W-1:0]    op_a,
   input  logic signed [spmv_pkg::MUL_W-1:0]    op_b,
   output logic signed [spmv_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [spmv_pkg::PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[hdl/csr_sparse_matrix_vector_multiply.sv]
// Channel   Direction  tdata                                      tlast     tuser
// req_      in         x_index, x_value, matrix_value, column,    row_end   action
//                      old_y, matrix_end (120 bits)
// rsp_      out        new_y (32 bits)                            last_row  column_error,
//                                                                           saturated
// csr_      in         write port: index 0 alpha, 1 beta, 2 vector length
//
// A load request leaves the sequencer idle, so loads can stream every clock while no
// nonzero or row close holds req_tready low. A nonzero request passes through x store
// read, multiply and saturating accumulate. Closing a row runs on the shared multiplier
// and adder (alpha times low word, alpha times high word, beta times old y, final add,
// saturate and hand over), stalling at hand-over while a previous result waits on rsp_.
// Reset is synchronous and active high; the x store holds no reset value.
// The result register accepts new work while its result waits; only a second row close
// stalls until rsp_tready takes the waiting result.
module csr_sparse_matrix_vector_multiply (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [9:0] x_index, [41:10] x_value, [73:42] matrix_value, [83:74] column,
   // [115:84] old_y, [116] matrix_end, [119:117] zero
   input  logic [spmv_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tlast,   // row_end
   input  logic [1:0]                            req_tuser,   // [1:0] action

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [spmv_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // [31:0] new_y
   output logic                                  rsp_tlast,   // last_row
   // [0] column_error, [1] saturated
   output logic [spmv_pkg::RSP_USER_W-1:0]       rsp_tuser,

   input  logic                                  csr_wr_en,
   input  logic [spmv_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [spmv_pkg::VALUE_WIDTH-1:0]      csr_wr_data
);

   localparam int VW = spmv_pkg::VALUE_WIDTH;
   localparam int AW = spmv_pkg::X_ADDR_W;
   localparam int MW = spmv_pkg::MUL_W;
   localparam int PW = spmv_pkg::PROD_W;
   localparam int CW = spmv_pkg::ACC_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NZ_MUL,
      ST_NZ_ACC,
      ST_CL_LO,
      ST_CL_HI,
      ST_CL_BETA,
      ST_CL_SUM,
      ST_CL_OUT
   } state_type;

   state_type state_ff;

   // Configuration.
   logic signed [VW-1:0]          alpha_ff;
   logic signed [VW-1:0]          beta_ff;
   logic [spmv_pkg::VLEN_W-1:0]   vlen_ff;

   // The x vector lives in a single-port-write, single-port-read memory.
   logic [VW-1:0] x_mem [spmv_pkg::X_DEPTH];
   logic [VW-1:0] x_rd_ff;

   // Request fields.
   spmv_pkg::action_type action;
   logic [AW-1:0]        req_x_index;
   logic [VW-1:0]        req_x_value;
   logic [VW-1:0]        req_matrix_value;
   logic [AW-1:0]        req_column;
   logic [VW-1:0]        req_old_y;
   logic                 req_matrix_end;
   logic                 req_fire;
   logic                 col_ok;

   // Latched request payload.
   logic [VW-1:0] mv_ff;
   logic [VW-1:0] old_y_ff;
   logic          row_end_ff;
   logic          last_ff;

   // Row state.
   logic signed [CW-1:0] sum_ff;
   logic                 bad_col_ff;
   logic                 clipped_ff;

   // Shared multiplier and the row-close accumulator.
   logic signed [MW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] t_ff;

   // Saturating accumulate.
   logic signed [CW:0]   sum_wide;
   logic signed [CW-1:0] sum_in;
   logic                 sum_ovf;

   // Output saturation.
   logic [PW-VW:0]  t_top;
   logic            t_fits;
   logic [VW-1:0]   y_in;

   // Output register.
   logic                 rsp_valid_ff;
   logic [VW-1:0]        rsp_y_ff;
   logic                 rsp_last_ff;
   logic                 rsp_bad_ff;
   logic                 rsp_sat_ff;
   logic                 out_free;

   assign action           = spmv_pkg::action_type'(req_tuser);
   assign req_x_index      = req_tdata[spmv_pkg::XI_LSB +: AW];
   assign req_x_value      = req_tdata[spmv_pkg::XV_LSB +: VW];
   assign req_matrix_value = req_tdata[spmv_pkg::MV_LSB +: VW];
   assign req_column       = req_tdata[spmv_pkg::COL_LSB +: AW];
   assign req_old_y        = req_tdata[spmv_pkg::OY_LSB +: VW];
   assign req_matrix_end   = req_tdata[spmv_pkg::ME_BIT];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // A column is usable when it is below both the loaded length and the store depth.
   assign col_ok = ({1'b0, req_column} < vlen_ff) &&
                   ({1'b0, req_column} < spmv_pkg::X_DEPTH_LEN);

   always_ff @(posedge clock) begin
      if (req_fire && action == spmv_pkg::ACT_LOAD &&
          {1'b0, req_x_index} < spmv_pkg::X_DEPTH_LEN) begin
         x_mem[req_x_index] <= req_x_value;
      end
      if (req_fire && action == spmv_pkg::ACT_NONZERO) begin
         x_rd_ff <= x_mem[req_column];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= spmv_pkg::ALPHA_RESET;
         beta_ff  <= '0;
         vlen_ff  <= spmv_pkg::VLEN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            spmv_pkg::CSR_ALPHA: alpha_ff <= csr_wr_data;
            spmv_pkg::CSR_BETA:  beta_ff  <= csr_wr_data;
            spmv_pkg::CSR_VLEN:  vlen_ff  <= csr_wr_data[spmv_pkg::VLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiplier. The low accumulator word enters
   // unsigned; the high word and every value enter sign extended.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_NZ_MUL: begin
            mul_a = {mv_ff[VW-1], mv_ff};
            mul_b = {x_rd_ff[VW-1], x_rd_ff};
         end
         ST_CL_LO: begin
            mul_a = {alpha_ff[VW-1], alpha_ff};
            mul_b = {1'b0, sum_ff[VW-1:0]};
         end
         ST_CL_HI: begin
            mul_a = {alpha_ff[VW-1], alpha_ff};
            mul_b = {sum_ff[CW-1], sum_ff[CW-1:VW]};
         end
         ST_CL_BETA: begin
            mul_a = {beta_ff[VW-1], beta_ff};
            mul_b = {old_y_ff[VW-1], old_y_ff};
         end
         default: ;
      endcase
   end

   spmv_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // The nonzero product always fits the accumulator width, so its low bits are exact.
   assign sum_wide = {sum_ff[CW-1], sum_ff} + {prod[CW-1], prod[CW-1:0]};
   assign sum_ovf  = sum_wide[CW] != sum_wide[CW-1];
   always_comb begin
      if (!sum_ovf) begin
         sum_in = sum_wide[CW-1:0];
      end else if (sum_wide[CW]) begin
         sum_in = {1'b1, {(CW-1){1'b0}}};
      end else begin
         sum_in = {1'b0, {(CW-1){1'b1}}};
      end
   end

   // The result fits when every bit above the value's sign bit equals it.
   assign t_top  = t_ff[PW-1:VW-1];
   assign t_fits = (&t_top) || !(|t_top);
   always_comb begin
      if (t_fits) begin
         y_in = t_ff[VW-1:0];
      end else if (t_ff[PW-1]) begin
         y_in = {1'b1, {(VW-1){1'b0}}};
      end else begin
         y_in = {1'b0, {(VW-1){1'b1}}};
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer, row state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         bad_col_ff   <= 1'b0;
         clipped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A row that hands over in this cycle sets the valid flag itself.
         if (rsp_valid_ff && rsp_tready && state_ff != ST_CL_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  mv_ff      <= req_matrix_value;
                  old_y_ff   <= req_old_y;
                  row_end_ff <= req_tlast;
                  last_ff    <= req_matrix_end;
                  case (action)
                     spmv_pkg::ACT_NONZERO: begin
                        if (col_ok) begin
                           state_ff <= ST_NZ_MUL;
                        end else begin
                           bad_col_ff <= 1'b1;
                           if (req_tlast) begin
                              state_ff <= ST_CL_LO;
                           end
                        end
                     end
                     spmv_pkg::ACT_EMPTY: begin
                        state_ff <= ST_CL_LO;
                     end
                     default: ;
                  endcase
               end
            end
            ST_NZ_MUL: begin
               state_ff <= ST_NZ_ACC;
            end
            ST_NZ_ACC: begin
               sum_ff <= sum_in;
               if (sum_ovf) begin
                  clipped_ff <= 1'b1;
               end
               state_ff <= row_end_ff ? ST_CL_LO : ST_IDLE;
            end
            ST_CL_LO: begin
               state_ff <= ST_CL_HI;
            end
            ST_CL_HI: begin
               // Floor of alpha times the low word over 2^32.
               t_ff     <= prod >>> VW;
               state_ff <= ST_CL_BETA;
            end
            ST_CL_BETA: begin
               t_ff     <= t_ff + prod;
               state_ff <= ST_CL_SUM;
            end
            ST_CL_SUM: begin
               // A zero beta gives a zero product, so old y drops out by itself.
               t_ff     <= t_ff + (prod >>> spmv_pkg::BETA_SHIFT);
               state_ff <= ST_CL_OUT;
            end
            ST_CL_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_y_ff     <= y_in;
                  rsp_last_ff  <= last_ff;
                  rsp_bad_ff   <= bad_col_ff;
                  rsp_sat_ff   <= clipped_ff || !t_fits;
                  sum_ff       <= '0;
                  bad_col_ff   <= 1'b0;
                  clipped_ff   <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_y_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_bad_ff};

endmodule

[hdl/spmv_checker.sv]
`include "assert_macros.svh"

// Port-level checks of the sparse matrix-vector block.
module spmv_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [1:0]                            req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [spmv_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input logic                                  rsp_tlast,
   input logic [spmv_pkg::RSP_USER_W-1:0]       rsp_tuser
);

   // A waiting result stays offered until it is taken.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid,
      "rsp_tvalid dropped while stalled")

   // A waiting result keeps its value and flags.
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset,
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser) &&
         $stable(rsp_tlast),
      "rsp payload changed while stalled")

   // An empty row always starts the row close, so no request is taken next.
   `ASSERT_CLK_RST(a_empty_busy, clock, reset,
      req_tvalid && req_tready && req_tuser == spmv_pkg::ACT_EMPTY |=> !req_tready,
      "request taken during row close")

   // Reset leaves no result pending.
   `ASSERT_CLK(a_reset_clear, clock, reset |=> !rsp_tvalid, "result pending after reset")

endmodule

bind csr_sparse_matrix_vector_multiply spmv_checker u_spmv_checker (.*);
